// ===== rtl/mqst_pkg.sv =====
package mqst_pkg;

	// Field widths of the request and response items
	localparam int CMD_W   = 1;
	localparam int IDX_W   = 6;
	localparam int TGT_W   = 3;
	localparam int COUNT_W = 7;

	localparam int NUM_QUEUES       = 6;
	localparam int POOL_ENTRIES_DEF = 64;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_MOVE = 1'b0;
	localparam logic [CMD_W-1:0] CMD_PEEK = 1'b1;

	// State codes: undefined, then the six queue states
	localparam logic [TGT_W-1:0] ST_UNDEF       = 3'd0;
	localparam logic [TGT_W-1:0] ST_FIRST_QUEUE = 3'd1;
	localparam logic [TGT_W-1:0] ST_LAST_QUEUE  = 3'd6;

	// Controller to datapath
	typedef struct packed {
		logic clear;
		logic accept;
		logic detach;
		logic attach;
		logic link;
		logic reply;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clear_last;
		logic move_ok;
		logic tgt_queue;
	} dp_sts_t;

	function automatic logic is_queue(input logic [TGT_W-1:0] s);
		return (s >= ST_FIRST_QUEUE) && (s <= ST_LAST_QUEUE);
	endfunction

endpackage

// ===== rtl/mqst_ifs.sv =====
interface mqst_cmd_if import mqst_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] command;
	logic [IDX_W-1:0] entry_index;
	logic [TGT_W-1:0] target_state;

	modport source(output valid, command, entry_index, target_state, input ready);
	modport sink(input valid, command, entry_index, target_state, output ready);
endinterface

interface mqst_rsp_if import mqst_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               found;
	logic [IDX_W-1:0]   head_entry;
	logic [COUNT_W-1:0] state_count;

	modport source(output valid, found, head_entry, state_count, input ready);
	modport sink(input valid, found, head_entry, state_count, output ready);
endinterface

// ===== rtl/mqst_ctrl.sv =====
module mqst_ctrl import mqst_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  dp_sts_t sts,
	output dp_cmd_t ctl
);

	typedef enum logic [5:0] {
		S_CLEAR  = 6'b000001,
		S_IDLE   = 6'b000010,
		S_DETACH = 6'b000100,
		S_ATTACH = 6'b001000,
		S_LINK   = 6'b010000,
		S_REPLY  = 6'b100000
	} fsm_t;

	fsm_t state_q, state_d;
	logic out_valid_q;

	always_comb begin
		ctl        = '0;
		ctl.clear  = (state_q == S_CLEAR);
		ctl.accept = (state_q == S_IDLE) && in_valid;
		ctl.detach = (state_q == S_DETACH);
		ctl.attach = (state_q == S_ATTACH);
		ctl.link   = (state_q == S_LINK);
		ctl.reply  = (state_q == S_REPLY) && (!out_valid_q || out_ready);
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (sts.clear_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) state_d = S_DETACH;
			end
			S_DETACH: begin
				state_d = (sts.move_ok && sts.tgt_queue) ? S_ATTACH : S_REPLY;
			end
			S_ATTACH: state_d = S_LINK;
			S_LINK:   state_d = S_REPLY;
			S_REPLY: begin
				if (!out_valid_q || out_ready) state_d = S_IDLE;
			end
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.reply) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/mqst_dp.sv =====
module mqst_dp import mqst_pkg::*; #(
	parameter int POOL_ENTRIES = POOL_ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            ctl,
	output dp_sts_t            sts,
	input  logic [CMD_W-1:0]   in_command,
	input  logic [IDX_W-1:0]   in_entry_index,
	input  logic [TGT_W-1:0]   in_target_state,
	output logic               out_found,
	output logic [IDX_W-1:0]   out_head_entry,
	output logic [COUNT_W-1:0] out_state_count
);

	localparam int AW = $clog2(POOL_ENTRIES);
	localparam int LW = $clog2(POOL_ENTRIES + 1);
	localparam logic [LW-1:0] NULL_LINK = LW'(POOL_ENTRIES);
	localparam logic [AW-1:0] LAST_ADDR = AW'(POOL_ENTRIES - 1);

	logic [TGT_W-1:0] state_mem [POOL_ENTRIES];
	logic [LW-1:0]    next_mem  [POOL_ENTRIES];
	logic [LW-1:0]    prev_mem  [POOL_ENTRIES];

	logic [LW-1:0] list_head_q  [NUM_QUEUES];
	logic [LW-1:0] list_tail_q  [NUM_QUEUES];
	logic [LW-1:0] list_count_q [NUM_QUEUES];

	logic [CMD_W-1:0]   cmd_q;
	logic [IDX_W-1:0]   idx_q;
	logic [TGT_W-1:0]   tgt_q;
	logic [TGT_W-1:0]   state_rd_q;
	logic [LW-1:0]      next_rd_q;
	logic [LW-1:0]      prev_rd_q;
	logic [LW-1:0]      old_tail_q;
	logic [AW-1:0]      clr_addr_q;
	logic               found_q;
	logic [IDX_W-1:0]   head_entry_q;
	logic [COUNT_W-1:0] count_q;

	logic [AW-1:0]    e_addr;
	logic [LW-1:0]    e_link;
	logic             in_range;
	logic             tgt_queue;
	logic             src_queue;
	logic             move_ok;
	logic             p_valid;
	logic             n_valid;
	logic [TGT_W-1:0] qsel;
	logic [LW-1:0]    head_sel;
	logic [LW-1:0]    tail_sel;
	logic [LW-1:0]    count_sel;

	assign e_addr    = AW'(idx_q);
	assign e_link    = LW'(idx_q);
	assign in_range  = int'(idx_q) < POOL_ENTRIES;
	assign tgt_queue = is_queue(tgt_q);
	assign src_queue = is_queue(state_rd_q);
	assign move_ok   = (cmd_q == CMD_MOVE) && in_range && (tgt_q <= ST_LAST_QUEUE)
		&& (state_rd_q != tgt_q);
	assign p_valid   = prev_rd_q < NULL_LINK;
	assign n_valid   = next_rd_q < NULL_LINK;

	// one list port: the old list while unlinking, the target list otherwise
	assign qsel = ctl.detach ? state_rd_q : tgt_q;

	always_comb begin
		head_sel  = NULL_LINK;
		tail_sel  = NULL_LINK;
		count_sel = '0;
		for (int k = 0; k < NUM_QUEUES; k++) begin
			if (qsel == TGT_W'(k + 1)) begin
				head_sel  = list_head_q[k];
				tail_sel  = list_tail_q[k];
				count_sel = list_count_q[k];
			end
		end
	end

	assign sts.clear_last = (clr_addr_q == LAST_ADDR);
	assign sts.move_ok    = move_ok;
	assign sts.tgt_queue  = tgt_queue;

	// list heads, tails and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_QUEUES; k++) begin
				list_head_q[k]  <= NULL_LINK;
				list_tail_q[k]  <= NULL_LINK;
				list_count_q[k] <= '0;
			end
			clr_addr_q <= '0;
		end else begin
			if (ctl.clear && !sts.clear_last) clr_addr_q <= clr_addr_q + 1'b1;
			for (int k = 0; k < NUM_QUEUES; k++) begin
				if (qsel == TGT_W'(k + 1)) begin
					if (ctl.detach && move_ok && src_queue) begin
						if (!p_valid) list_head_q[k] <= next_rd_q;
						if (!n_valid) list_tail_q[k] <= prev_rd_q;
						if (list_count_q[k] != '0) list_count_q[k] <= list_count_q[k] - 1'b1;
					end
					if (ctl.attach) begin
						if (tail_sel >= NULL_LINK) list_head_q[k] <= e_link;
						list_tail_q[k]  <= e_link;
						list_count_q[k] <= list_count_q[k] + 1'b1;
					end
				end
			end
		end
	end

	// request, read data and response registers
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q <= in_command;
			idx_q <= in_entry_index;
			tgt_q <= in_target_state;
		end
		if (ctl.attach) old_tail_q <= tail_sel;
		if (ctl.reply) begin
			found_q      <= (cmd_q == CMD_PEEK) && tgt_queue && (head_sel < NULL_LINK);
			head_entry_q <= ((cmd_q == CMD_PEEK) && tgt_queue && (head_sel < NULL_LINK))
				? IDX_W'(head_sel) : '0;
			count_q      <= tgt_queue ? COUNT_W'(count_sel) : '0;
		end
	end

	// entry state memory
	always_ff @(posedge clk) begin
		if (ctl.clear) state_mem[clr_addr_q] <= ST_UNDEF;
		else if (ctl.detach && move_ok) state_mem[e_addr] <= tgt_q;
		if (ctl.accept) state_rd_q <= state_mem[AW'(in_entry_index)];
	end

	// forward link memory
	always_ff @(posedge clk) begin
		if (ctl.detach && move_ok && src_queue && p_valid)
			next_mem[AW'(prev_rd_q)] <= next_rd_q;
		else if (ctl.attach)
			next_mem[e_addr] <= NULL_LINK;
		else if (ctl.link && (old_tail_q < NULL_LINK))
			next_mem[AW'(old_tail_q)] <= e_link;
		if (ctl.accept) next_rd_q <= next_mem[AW'(in_entry_index)];
	end

	// backward link memory
	always_ff @(posedge clk) begin
		if (ctl.detach && move_ok && src_queue && n_valid)
			prev_mem[AW'(next_rd_q)] <= prev_rd_q;
		else if (ctl.attach)
			prev_mem[e_addr] <= tail_sel;
		if (ctl.accept) prev_rd_q <= prev_mem[AW'(in_entry_index)];
	end

	assign out_found       = found_q;
	assign out_head_entry  = head_entry_q;
	assign out_state_count = count_q;

endmodule

// ===== rtl/multi_queue_state_tracker.sv =====
// Channel  Dir  Handshake     Payload
// cmd      in   valid/ready   command, entry_index, target_state
// rsp      out  valid/ready   found, head_entry, state_count
//
// A move into a queue steps through accept and read entry, unlink from the old list,
// append at the target tail, link the old tail and respond; the response register is
// loaded at the respond step. A peek, a move to undefined or a move that changes
// nothing skips the append and link steps. cmd.ready is high only while idle, so
// a new request waits until the last has been through its respond step. The link
// memories have one write port each. After reset a sweep over all POOL_ENTRIES
// entries clears the entry state memory; cmd.ready stays low until it finishes. A
// response held by rsp.ready stalls the next request only at its response step.
module multi_queue_state_tracker import mqst_pkg::*; #(
	parameter int POOL_ENTRIES = POOL_ENTRIES_DEF
) (
	input logic       clk,
	input logic       arst_n,
	mqst_cmd_if.sink  cmd,
	mqst_rsp_if.source rsp
);

	// command and status between the sequencer and the list datapath
	dp_cmd_t ctl;
	dp_sts_t sts;

	// sequence each request: accept, unlink, append, link, respond
	mqst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_ready  (cmd.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	// hold entry states, link memories, list heads, tails and counts
	mqst_dp #(
		.POOL_ENTRIES(POOL_ENTRIES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.sts             (sts),
		.in_command      (cmd.command),
		.in_entry_index  (cmd.entry_index),
		.in_target_state (cmd.target_state),
		.out_found       (rsp.found),
		.out_head_entry  (rsp.head_entry),
		.out_state_count (rsp.state_count)
	);

endmodule
